// ----- src/lsbx_pkg.sv -----
// Shared types and constants for the LSB hidden-frame extractor.
`timescale 1ns / 1ps

package lsbx_pkg;

    // Parser phases of the hidden bit stream.
    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_MAGIC    = 3'd1,
        PH_EXT_LEN  = 3'd2,
        PH_EXT      = 3'd3,
        PH_DATA_LEN = 3'd4,
        PH_DATA     = 3'd5,
        PH_HALT     = 3'd6
    } t_phase;

    // Result kinds.
    localparam logic [2:0] KIND_EXT_BYTE  = 3'd0;
    localparam logic [2:0] KIND_DATA_BYTE = 3'd1;
    localparam logic [2:0] KIND_MAGIC_ERR = 3'd2;
    localparam logic [2:0] KIND_EXT_LONG  = 3'd3;
    localparam logic [2:0] KIND_DONE_NONE = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MAGIC_VALUE  = 2'd0;
    localparam logic [1:0] REG_MAGIC_LENGTH = 2'd1;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

    localparam logic [7:0]  HEADER_BYTES_RESET = 8'd54;
    localparam logic [3:0]  MAGIC_MAX_BYTES    = 4'd8;
    localparam int unsigned CFG_ADDR_W         = 5;
    localparam int unsigned CFG_DATA_W         = 64;

    // What the front end hands to the parser for one image byte.
    typedef struct packed {
        logic restart;
        logic has_bit;
        logic hbit;
    } t_token;

    // One result item.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       last;
    } t_result;

    // Configuration values seen by the front end and the parser.
    typedef struct packed {
        logic [63:0] magic_value;
        logic [3:0]  magic_length;
        logic [7:0]  header_bytes;
    } t_cfg;

endpackage

// ----- src/lsbx_regs.sv -----
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps

module lsbx_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lsbx_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lsbx_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [lsbx_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output lsbx_pkg::t_cfg                   o_cfg
);
    import lsbx_pkg::*;

    logic [63:0] r_magic_value;
    logic [3:0]  r_magic_length;
    logic [7:0]  r_header_bytes;
    logic [1:0]  w_index;
    logic        w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[4:3];
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_value  <= '0;
            r_magic_length <= '0;
            r_header_bytes <= HEADER_BYTES_RESET;
        end else if (w_write) begin
            if (w_index == REG_MAGIC_VALUE) begin
                r_magic_value <= pwdata;
            end
            if (w_index == REG_MAGIC_LENGTH) begin
                r_magic_length <= pwdata[3:0];
            end
            if (w_index == REG_HEADER_BYTES) begin
                r_header_bytes <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        unique case (w_index)
            REG_MAGIC_VALUE:  prdata = r_magic_value;
            REG_MAGIC_LENGTH: prdata = {60'd0, r_magic_length};
            REG_HEADER_BYTES: prdata = {56'd0, r_header_bytes};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = '{magic_value: r_magic_value, magic_length: r_magic_length,
                     header_bytes: r_header_bytes};

endmodule

// ----- src/lsbx_fifo.sv -----
// Small synchronous queue with count-based full and empty flags.
`timescale 1ns / 1ps

module lsbx_fifo #(
    parameter int unsigned WIDTH = 3,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/lsbx_front.sv -----
// Front end: accepts image bytes, skips the header and tags hidden bits.
`timescale 1ns / 1ps

module lsbx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_frame_start,
    input  logic [7:0]        i_pixel_byte,
    input  logic [7:0]        i_header_bytes,
    output logic              o_valid,
    output lsbx_pkg::t_token  o_token
);
    import lsbx_pkg::*;

    logic       r_in_header;
    logic [7:0] r_skip_count;
    logic       n_in_header;
    logic [7:0] n_skip_count;
    logic       w_in_header;
    logic [7:0] w_skip_count;
    logic       w_skip;

    // A frame start rewinds the header count before this byte is judged.
    assign w_in_header  = i_frame_start ? 1'b1 : r_in_header;
    assign w_skip_count = i_frame_start ? 8'd0 : r_skip_count;
    assign w_skip       = w_in_header && (w_skip_count < i_header_bytes);

    always_comb begin
        n_in_header  = w_in_header && w_skip;
        n_skip_count = w_skip ? w_skip_count + 8'd1 : w_skip_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header  <= 1'b1;
            r_skip_count <= '0;
        end else if (i_valid) begin
            r_in_header  <= n_in_header;
            r_skip_count <= n_skip_count;
        end
    end

    assign o_token = '{restart: i_frame_start, has_bit: !w_skip, hbit: i_pixel_byte[0]};
    assign o_valid = i_valid && (i_frame_start || !w_skip);

endmodule

// ----- src/lsbx_back.sv -----
// Back end: parses the hidden bit stream and builds result items.
`timescale 1ns / 1ps

module lsbx_back #(
    parameter int unsigned MAX_EXT_LEN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lsbx_pkg::t_token   i_token,
    input  lsbx_pkg::t_cfg     i_cfg,
    output logic               o_emit,
    output lsbx_pkg::t_result  o_result
);
    import lsbx_pkg::*;

    t_phase      r_phase;
    logic [31:0] r_bit_shift;
    logic [4:0]  r_bit_index;
    logic [63:0] r_decoded_magic;
    logic [3:0]  r_magic_done;
    logic [4:0]  r_ext_remaining;
    logic [30:0] r_data_remaining;

    t_phase      n_phase;
    logic [31:0] n_bit_shift;
    logic [4:0]  n_bit_index;
    logic [63:0] n_decoded_magic;
    logic [3:0]  n_magic_done;
    logic [4:0]  n_ext_remaining;
    logic [30:0] n_data_remaining;

    t_phase      w_base_phase;
    t_phase      w_phase;
    logic [31:0] w_base_shift;
    logic [4:0]  w_base_index;
    logic [63:0] w_base_magic;
    logic [3:0]  w_base_done;
    logic [4:0]  w_base_ext;
    logic [30:0] w_base_data;
    logic [3:0]  w_mlen;
    logic        w_unit32;
    logic        w_active;
    logic        w_unit_done;
    logic [31:0] w_shift;
    logic [31:0] w_size;
    logic [63:0] w_magic;
    logic [3:0]  w_magic_cnt;
    logic [63:0] w_mask;
    logic        w_magic_ok;
    logic [4:0]  w_ext_dec;
    logic [30:0] w_data_dec;

    // A restart token parses from reset values.
    assign w_base_phase = i_token.restart ? PH_START : r_phase;
    assign w_base_shift = i_token.restart ? '0 : r_bit_shift;
    assign w_base_index = i_token.restart ? '0 : r_bit_index;
    assign w_base_magic = i_token.restart ? '0 : r_decoded_magic;
    assign w_base_done  = i_token.restart ? '0 : r_magic_done;
    assign w_base_ext   = i_token.restart ? '0 : r_ext_remaining;
    assign w_base_data  = i_token.restart ? '0 : r_data_remaining;

    assign w_mlen = (i_cfg.magic_length > MAGIC_MAX_BYTES) ? MAGIC_MAX_BYTES
                                                           : i_cfg.magic_length;

    // The first hidden bit of a frame picks the opening phase.
    always_comb begin
        if (w_base_phase == PH_START && i_token.has_bit) begin
            w_phase = (w_mlen == 4'd0) ? PH_EXT_LEN : PH_MAGIC;
        end else begin
            w_phase = w_base_phase;
        end
    end

    assign w_unit32 = (w_phase == PH_EXT_LEN) || (w_phase == PH_DATA_LEN);
    assign w_active = i_token.has_bit && (w_phase != PH_START) && (w_phase != PH_HALT);
    assign w_shift  = {w_base_shift[30:0], i_token.hbit};
    assign w_unit_done = w_unit32 ? (w_base_index == 5'd31) : (w_base_index >= 5'd7);
    assign w_size   = w_shift[31] ? 32'd0 : w_shift;
    assign w_magic  = {w_base_magic[55:0], w_shift[7:0]};
    assign w_magic_cnt = (w_base_done < 4'd15) ? w_base_done + 4'd1 : w_base_done;
    assign w_ext_dec   = (w_base_ext != '0) ? w_base_ext - 5'd1 : w_base_ext;
    assign w_data_dec  = (w_base_data != '0) ? w_base_data - 31'd1 : w_base_data;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_mask[i*8 +: 8] = (4'(i) < w_mlen) ? 8'hFF : 8'h00;
        end
    end

    assign w_magic_ok = ((w_magic ^ i_cfg.magic_value) & w_mask) == '0;

    // Next phase.
    always_comb begin
        n_phase = w_phase;
        if (w_active && w_unit_done) begin
            unique case (w_phase)
                PH_MAGIC: begin
                    if (w_magic_cnt >= w_mlen) begin
                        n_phase = w_magic_ok ? PH_EXT_LEN : PH_HALT;
                    end
                end
                PH_EXT_LEN: begin
                    if (w_size > 32'(MAX_EXT_LEN)) begin
                        n_phase = PH_HALT;
                    end else begin
                        n_phase = (w_size == '0) ? PH_DATA_LEN : PH_EXT;
                    end
                end
                PH_EXT: begin
                    if (w_ext_dec == '0) begin
                        n_phase = PH_DATA_LEN;
                    end
                end
                PH_DATA_LEN: begin
                    n_phase = (w_size == '0) ? PH_HALT : PH_DATA;
                end
                PH_DATA: begin
                    if (w_data_dec == '0) begin
                        n_phase = PH_HALT;
                    end
                end
                default: n_phase = PH_HALT;
            endcase
        end
    end

    // Datapath registers.
    always_comb begin
        n_bit_shift      = w_base_shift;
        n_bit_index      = w_base_index;
        n_decoded_magic  = w_base_magic;
        n_magic_done     = w_base_done;
        n_ext_remaining  = w_base_ext;
        n_data_remaining = w_base_data;
        if (w_active) begin
            n_bit_shift = w_shift;
            n_bit_index = w_unit_done ? 5'd0 : w_base_index + 5'd1;
            if (w_unit_done) begin
                unique case (w_phase)
                    PH_MAGIC: begin
                        n_decoded_magic = w_magic;
                        n_magic_done    = w_magic_cnt;
                    end
                    PH_EXT_LEN: begin
                        if (w_size <= 32'(MAX_EXT_LEN)) begin
                            n_ext_remaining = w_size[4:0];
                        end
                    end
                    PH_EXT:      n_ext_remaining  = w_ext_dec;
                    PH_DATA_LEN: begin
                        if (w_size != '0) begin
                            n_data_remaining = w_size[30:0];
                        end
                    end
                    PH_DATA:     n_data_remaining = w_data_dec;
                    default:     n_bit_shift      = w_shift;
                endcase
            end
        end
    end

    // Result item.
    always_comb begin
        o_emit   = 1'b0;
        o_result = '{kind: KIND_EXT_BYTE, data_byte: 8'd0, last: 1'b0};
        if (i_valid && w_active && w_unit_done) begin
            unique case (w_phase)
                PH_MAGIC: begin
                    if (w_magic_cnt >= w_mlen && !w_magic_ok) begin
                        o_emit   = 1'b1;
                        o_result = '{kind: KIND_MAGIC_ERR, data_byte: 8'd0, last: 1'b1};
                    end
                end
                PH_EXT_LEN: begin
                    if (w_size > 32'(MAX_EXT_LEN)) begin
                        o_emit   = 1'b1;
                        o_result = '{kind: KIND_EXT_LONG, data_byte: 8'd0, last: 1'b1};
                    end
                end
                PH_EXT: begin
                    o_emit   = 1'b1;
                    o_result = '{kind: KIND_EXT_BYTE, data_byte: w_shift[7:0], last: 1'b0};
                end
                PH_DATA_LEN: begin
                    if (w_size == '0) begin
                        o_emit   = 1'b1;
                        o_result = '{kind: KIND_DONE_NONE, data_byte: 8'd0, last: 1'b1};
                    end
                end
                PH_DATA: begin
                    o_emit   = 1'b1;
                    o_result = '{kind: KIND_DATA_BYTE, data_byte: w_shift[7:0],
                                 last: (w_data_dec == '0)};
                end
                default: o_emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_START;
            r_bit_shift      <= '0;
            r_bit_index      <= '0;
            r_decoded_magic  <= '0;
            r_magic_done     <= '0;
            r_ext_remaining  <= '0;
            r_data_remaining <= '0;
        end else if (i_valid) begin
            r_phase          <= n_phase;
            r_bit_shift      <= n_bit_shift;
            r_bit_index      <= n_bit_index;
            r_decoded_magic  <= n_decoded_magic;
            r_magic_done     <= n_magic_done;
            r_ext_remaining  <= n_ext_remaining;
            r_data_remaining <= n_data_remaining;
        end
    end

endmodule

// ----- src/lsb_stego_frame_extractor_core.sv -----
// One image byte per cycle while full is low; the parser handles one queued bit each
// cycle while the result queue has room. A four-entry request queue registers tokens
// between the header stage and the parser, and another four-entry queue registers
// results, so each side can stall on its own.
// Reset (synchronous, active low) empties both queues, restarts parsing at the header
// and sets header_bytes to 54, magic_value and magic_length to zero.
`timescale 1ns / 1ps

module lsb_stego_frame_extractor_core #(
    parameter int unsigned MAX_EXT_LEN = 16,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lsbx_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lsbx_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [lsbx_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             push,
    output logic                             full,
    input  logic                             i_frame_start,
    input  logic [7:0]                       i_pixel_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [2:0]                       o_out_kind,
    output logic [7:0]                       o_out_byte,
    output logic                             o_is_last
);
    import lsbx_pkg::*;

    t_cfg    w_cfg;
    t_token  w_front_token;
    t_token  w_back_token;
    t_result w_result;
    t_result w_out;
    logic    w_front_valid;
    logic    w_mid_full;
    logic    w_mid_empty;
    logic    w_out_full;
    logic    w_back_go;
    logic    w_emit;

    lsbx_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign full = w_mid_full;

    lsbx_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (push && !w_mid_full),
        .i_frame_start  (i_frame_start),
        .i_pixel_byte   (i_pixel_byte),
        .i_header_bytes (w_cfg.header_bytes),
        .o_valid        (w_front_valid),
        .o_token        (w_front_token)
    );

    lsbx_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_token),
        .o_full  (w_mid_full),
        .i_pop   (w_back_go),
        .o_data  (w_back_token),
        .o_empty (w_mid_empty)
    );

    // The parser only advances while there is room for a possible result.
    assign w_back_go = !w_mid_empty && !w_out_full;

    lsbx_back #(
        .MAX_EXT_LEN (MAX_EXT_LEN)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_back_go),
        .i_token  (w_back_token),
        .i_cfg    (w_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    lsbx_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_data  (w_result),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_empty (empty)
    );

    assign o_out_kind = w_out.kind;
    assign o_out_byte = w_out.data_byte;
    assign o_is_last  = w_out.last;

endmodule

// ----- dv/tb.sv -----
// Testbench for the LSB hidden-frame extractor: random image frames checked by a predictor.
`timescale 1ns / 1ps

module tb;
    import lsbx_pkg::*;

    localparam int unsigned EXT_LIMIT    = 16;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned PHASE_ITEMS  = 70;
    localparam int unsigned TX_IDLE[4]   = '{0, 58, 0, 12};
    localparam int unsigned RX_STALL[4]  = '{0, 0, 58, 12};

    class lsb_frame_scoreboard;
        logic [63:0] magic_value;
        logic [3:0]  magic_length;
        logic [7:0]  header_bytes;

        t_phase      phase;
        logic [7:0]  skip_cnt;
        logic [31:0] shift_reg;
        logic [4:0]  bit_idx;
        logic [63:0] magic_acc;
        logic [3:0]  magic_done;
        logic [4:0]  ext_left;
        logic [30:0] data_left;

        t_result     results_awaited[$];
        int unsigned results_predicted;
        int unsigned error_count;

        function new();
            magic_value = 64'd0;
            magic_length = 4'd0;
            header_bytes = HEADER_BYTES_RESET;
            results_predicted = 0;
            error_count = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase = PH_START;
            skip_cnt = '0;
            shift_reg = '0;
            bit_idx = '0;
            magic_acc = '0;
            magic_done = '0;
            ext_left = '0;
            data_left = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_MAGIC_VALUE: magic_value = val;
                REG_MAGIC_LENGTH: magic_length = val[3:0];
                REG_HEADER_BYTES: header_bytes = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [3:0] magic_used();
            return (magic_length > MAGIC_MAX_BYTES) ? MAGIC_MAX_BYTES : magic_length;
        endfunction

        // Shifts one hidden bit in; true when a unit of the given width is complete.
        function bit shift_in(logic hb, int unsigned width);
            shift_reg = {shift_reg[30:0], hb};
            if (bit_idx >= width - 1) begin
                bit_idx = '0;
                return 1'b1;
            end
            bit_idx++;
            return 1'b0;
        endfunction

        function void await_result(logic [2:0] kind, logic [7:0] data, logic last);
            t_result r;
            r.kind = kind;
            r.data_byte = data;
            r.last = last;
            results_awaited.push_back(r);
            results_predicted++;
        endfunction

        function void decode_pixel(logic fs, logic [7:0] pb);
            logic [31:0] size_word;
            logic [3:0]  used;
            logic [63:0] mask;
            if (fs)
                clear_frame();
            if (phase == PH_START) begin
                if (skip_cnt < header_bytes) begin
                    skip_cnt++;
                    return;
                end
                phase = (magic_used() == 4'd0) ? PH_EXT_LEN : PH_MAGIC;
            end
            case (phase)
                PH_MAGIC: begin
                    if (shift_in(pb[0], 8)) begin
                        magic_acc = {magic_acc[55:0], shift_reg[7:0]};
                        if (magic_done < 4'd15)
                            magic_done++;
                        used = magic_used();
                        if (magic_done >= used) begin
                            mask = (used >= 4'd8) ? {64{1'b1}} : (64'd1 << (8 * used)) - 64'd1;
                            if ((magic_acc & mask) != (magic_value & mask)) begin
                                phase = PH_HALT;
                                await_result(KIND_MAGIC_ERR, 8'd0, 1'b1);
                            end else begin
                                phase = PH_EXT_LEN;
                            end
                        end
                    end
                end
                PH_EXT_LEN: begin
                    if (shift_in(pb[0], 32)) begin
                        // A size word with the sign bit set counts as zero.
                        size_word = shift_reg[31] ? 32'd0 : shift_reg;
                        if (size_word > EXT_LIMIT) begin
                            phase = PH_HALT;
                            await_result(KIND_EXT_LONG, 8'd0, 1'b1);
                        end else begin
                            ext_left = size_word[4:0];
                            phase = (size_word == 32'd0) ? PH_DATA_LEN : PH_EXT;
                        end
                    end
                end
                PH_EXT: begin
                    if (shift_in(pb[0], 8)) begin
                        if (ext_left != 5'd0)
                            ext_left--;
                        if (ext_left == 5'd0)
                            phase = PH_DATA_LEN;
                        await_result(KIND_EXT_BYTE, shift_reg[7:0], 1'b0);
                    end
                end
                PH_DATA_LEN: begin
                    if (shift_in(pb[0], 32)) begin
                        size_word = shift_reg[31] ? 32'd0 : shift_reg;
                        if (size_word == 32'd0) begin
                            phase = PH_HALT;
                            await_result(KIND_DONE_NONE, 8'd0, 1'b1);
                        end else begin
                            data_left = size_word[30:0];
                            phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (shift_in(pb[0], 8)) begin
                        if (data_left != 31'd0)
                            data_left--;
                        if (data_left == 31'd0) begin
                            phase = PH_HALT;
                            await_result(KIND_DATA_BYTE, shift_reg[7:0], 1'b1);
                        end else begin
                            await_result(KIND_DATA_BYTE, shift_reg[7:0], 1'b0);
                        end
                    end
                end
                default: phase = PH_HALT;
            endcase
        endfunction

        task report_mismatch(string what);
            if (error_count < 50)
                $display("[%0t] mismatch: %s", $time, what);
            error_count++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (results_awaited.size() == 0) begin
                report_mismatch($sformatf("result with none awaited: kind %0d byte %02h last %0b",
                                          got.kind, got.data_byte, got.last));
                return;
            end
            want = results_awaited.pop_front();
            if (got.kind != want.kind)
                report_mismatch($sformatf("kind %0d, awaited %0d", got.kind, want.kind));
            if (got.data_byte != want.data_byte)
                report_mismatch($sformatf("byte %02h, awaited %02h", got.data_byte,
                                          want.data_byte));
            if (got.last != want.last)
                report_mismatch($sformatf("last %0b, awaited %0b", got.last, want.last));
        endtask

        task check_drained();
            if (results_awaited.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", results_awaited.size()));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    logic                  i_frame_start;
    logic [7:0]            i_pixel_byte;
    logic                  empty;
    logic                  pop;
    logic [2:0]            o_out_kind;
    logic [7:0]            o_out_byte;
    logic                  o_is_last;

    lsb_frame_scoreboard board;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned items_sent = 0;
    bit          frame_bits[$];

    lsb_stego_frame_extractor_core #(
        .MAX_EXT_LEN(EXT_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .push(push),
        .full(full),
        .i_frame_start(i_frame_start),
        .i_pixel_byte(i_pixel_byte),
        .empty(empty),
        .pop(pop),
        .o_out_kind(o_out_kind),
        .o_out_byte(o_out_byte),
        .o_is_last(o_is_last)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Result side: values read right after the edge are the ones the block saw at it.
    initial begin
        t_result seen;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                seen.kind = o_out_kind;
                seen.data_byte = o_out_byte;
                seen.last = o_is_last;
                board.check_result(seen);
            end
            pop <= i_rst_n && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_byte(input logic fs, input logic [7:0] pb);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_frame_start <= fs;
        i_pixel_byte <= pb;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        board.decode_pixel(fs, pb);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 3'b000});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        board.set_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Bytes that cause no result may still be in flight once the last result is back.
    task automatic wait_idle();
        push <= 1'b0;
        while (board.results_awaited.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_field(logic [31:0] v, int unsigned width);
        for (int i = int'(width) - 1; i >= 0; i--)
            frame_bits.push_back(v[i]);
    endfunction

    // Builds the hidden bit stream of one frame for the current register settings.
    task automatic compose_frame(input logic [31:0] ext_word, input logic [31:0] data_word,
                                 input bit bad_magic);
        int unsigned used;
        int unsigned ext_n;
        int unsigned data_n;
        int unsigned flip;
        logic [63:0] sig;
        frame_bits.delete();
        used = (board.magic_length > MAGIC_MAX_BYTES) ? MAGIC_MAX_BYTES : board.magic_length;
        sig = board.magic_value;
        if (bad_magic && used != 0) begin
            flip = $urandom_range(0, 8 * used - 1);
            sig[flip] = ~sig[flip];
        end
        for (int k = int'(used) - 1; k >= 0; k--)
            add_field(32'(sig[8*k +: 8]), 8);
        add_field(ext_word, 32);
        ext_n = (!ext_word[31] && ext_word <= EXT_LIMIT) ? ext_word : 0;
        repeat (ext_n) add_field($urandom_range(0, 255), 8);
        add_field(data_word, 32);
        data_n = data_word[31] ? 0 : data_word;
        repeat (data_n) add_field($urandom_range(0, 255), 8);
    endtask

    task automatic send_bits(input int unsigned from, input int unsigned stop,
                             input bit fs_first);
        logic [7:0] pb;
        for (int unsigned i = from; i < stop; i++) begin
            pb = 8'($urandom);
            pb[0] = frame_bits[i];
            send_byte(fs_first && i == from, pb);
        end
    endtask

    // A negative cut sends the whole hidden stream.
    task automatic send_frame(input int unsigned hdr, input int cut);
        int unsigned stop;
        stop = (cut < 0) ? frame_bits.size() : cut;
        for (int unsigned i = 0; i < hdr; i++)
            send_byte(i == 0, 8'($urandom));
        send_bits(0, stop, hdr == 0);
    endtask

    task automatic random_frame();
        logic [31:0] ext_word;
        logic [31:0] data_word;
        int unsigned pick;
        int unsigned hdr;
        int          cut;
        pick = $urandom_range(99);
        if (pick < 72)
            ext_word = $urandom_range(0, 3);
        else if (pick < 80)
            ext_word = $urandom_range(EXT_LIMIT - 1, EXT_LIMIT);
        else if (pick < 85)
            ext_word = $urandom_range(EXT_LIMIT + 1, EXT_LIMIT + 4);
        else if (pick < 91)
            ext_word = $urandom_range(EXT_LIMIT + 1, 32'h7FFF_FFFF);
        else
            ext_word = {1'b1, 31'($urandom)};
        pick = $urandom_range(99);
        if (pick < 74)
            data_word = $urandom_range(1, 6);
        else if (pick < 82)
            data_word = 32'd0;
        else if (pick < 90)
            data_word = {1'b1, 31'($urandom)};
        else
            data_word = $urandom_range(7, 40);
        compose_frame(ext_word, data_word, $urandom_range(99) < 10);
        hdr = board.header_bytes;
        if ($urandom_range(99) < 6)
            hdr = (hdr == 0) ? 1 : hdr - 1;
        cut = ($urandom_range(99) < 10) ? int'($urandom_range(0, frame_bits.size() - 1)) : -1;
        send_frame(hdr, cut);
        repeat ($urandom_range(0, 3)) send_byte(1'b0, 8'($urandom));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 12)) send_byte(1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task automatic write_random_reg(input logic [1:0] idx);
        int unsigned pick;
        logic [63:0] val;
        pick = $urandom_range(99);
        case (idx)
            REG_MAGIC_VALUE:
                val = (pick < 10) ? 64'd0 : (pick < 20) ? {64{1'b1}} : {$urandom, $urandom};
            REG_MAGIC_LENGTH:
                val = (pick < 30) ? 64'd0 : (pick < 45) ? 64'd8 : 64'($urandom_range(0, 15));
            default:
                val = (pick < 55) ? 64'($urandom_range(0, 4)) :
                      (pick < 88) ? 64'($urandom_range(5, 24)) :
                      (pick < 96) ? 64'(HEADER_BYTES_RESET) : 64'd255;
        endcase
        write_reg(idx, val);
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned pick;
        board = new();
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        push <= 1'b0;
        i_frame_start <= 1'b0;
        i_pixel_byte <= 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Settings straight out of reset: 54 header bytes and no signature.
        compose_frame(32'd1, 32'd1, 1'b0);
        send_frame(HEADER_BYTES_RESET, -1);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        wait_idle();

        // An extension length one above the limit halts right after its size word; sign-bit and zero size words follow.
        write_reg(REG_HEADER_BYTES, 64'd0);
        write_reg(REG_MAGIC_LENGTH, 64'd0);
        compose_frame(EXT_LIMIT + 1, 32'd1, 1'b0);
        send_frame(0, 32);
        compose_frame(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_frame(0, -1);
        compose_frame(32'd0, 32'd0, 1'b0);
        send_frame(0, -1);
        wait_idle();

        // A length register above eight still checks all eight signature bytes.
        write_reg(REG_MAGIC_VALUE, {64{1'b1}});
        write_reg(REG_MAGIC_LENGTH, 64'd15);
        compose_frame(32'd0, 32'd1, 1'b0);
        send_frame(0, -1);
        compose_frame(32'd0, 32'd1, 1'b1);
        send_frame(0, 64);
        wait_idle();

        // A frame cut short, then restarted by the next frame start.
        write_reg(REG_MAGIC_VALUE, {$urandom, $urandom});
        write_reg(REG_MAGIC_LENGTH, 64'd3);
        compose_frame(32'd2, 32'd3, 1'b0);
        send_frame(0, frame_bits.size() / 2);
        compose_frame(32'd0, 32'd1, 1'b0);
        send_frame(0, -1);
        wait_idle();

        // Registers change in the middle of a frame, past the header and signature.
        write_reg(REG_HEADER_BYTES, 64'd2);
        write_reg(REG_MAGIC_LENGTH, 64'd0);
        compose_frame(32'd1, 32'd2, 1'b0);
        send_frame(2, 20);
        wait_idle();
        write_reg(REG_HEADER_BYTES, 64'd255);
        write_reg(REG_MAGIC_LENGTH, 64'd5);
        send_bits(20, frame_bits.size(), 1'b0);

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            tx_idle_pct = TX_IDLE[p];
            rx_stall_pct = RX_STALL[p];
            write_random_reg(REG_MAGIC_VALUE);
            write_random_reg(REG_MAGIC_LENGTH);
            write_random_reg(REG_HEADER_BYTES);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    wait_idle();
                    write_random_reg(2'($urandom_range(0, 2)));
                end
                if (pick >= 94)
                    noise_burst();
                else
                    random_frame();
            end
        end

        wait_idle();
        board.check_drained();
        if (board.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
